// File: sv/lwstat_pkg.sv
// lwstat_pkg: shared types and constants for the latency window statistics block
// no dependencies; used by the interfaces and by lwstat_front, lwstat_queue, lwstat_back and the top
package lwstat_pkg;

  localparam int ACT_W = 2;
  localparam int NS_W = 32;
  localparam int LAT_W = 23;
  localparam int BUF_W = 14;
  localparam int RATE_W = 19;
  localparam int AVG_W = 31;
  localparam int LOAD_W = 24;
  localparam int OVR_W = 32;
  localparam int FILL_OUT_W = 9;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 19;

  localparam logic [ACT_W-1:0] ACT_SAMPLE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_OVERRUN = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;
  // changes nothing, only reports the current values
  localparam logic [ACT_W-1:0] ACT_REPORT = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 1'd1;

  localparam logic [BUF_W-1:0] BUFFER_SIZE_RESET = 14'd512;
  localparam logic [RATE_W-1:0] SAMPLE_RATE_RESET = 19'd48000;

  // ns to us: floor(ns * 274877907 / 2^38) is exact for every 32-bit ns
  localparam int US_MAG_W = 29;
  localparam logic [US_MAG_W-1:0] US_MAGIC = 29'd274877907;
  localparam int US_SHIFT = 38;
  localparam int US_PROD_W = NS_W + US_MAG_W;

  localparam int SCALE_W = 14;
  localparam logic [SCALE_W-1:0] LOAD_SCALE = 14'd10000;
  localparam int FRAC_BITS = 8;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = 1;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [LAT_W-1:0] us;
  } cmd_t;

endpackage

// File: sv/lwstat_event_if.sv
// lwstat_event_if: input channel carrying one event beat
// depends on lwstat_pkg
interface lwstat_event_if;
  import lwstat_pkg::*;
  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] action;
  logic [NS_W-1:0]  elapsed_ns;
  modport source(output valid, action, elapsed_ns, input ready);
  modport sink(input valid, action, elapsed_ns, output ready);
endinterface

// File: sv/lwstat_stats_if.sv
// lwstat_stats_if: output channel carrying one statistics beat
// depends on lwstat_pkg
interface lwstat_stats_if;
  import lwstat_pkg::*;
  logic              valid;
  logic              ready;
  logic [AVG_W-1:0]  average_us_fx;
  logic [LAT_W-1:0]  peak_us;
  logic [OVR_W-1:0]  overrun_count;
  logic [LOAD_W-1:0] cpu_load_fx;
  logic [FILL_OUT_W-1:0] window_fill;
  modport source(output valid, average_us_fx, peak_us, overrun_count, cpu_load_fx,
                 window_fill, input ready);
  modport sink(input valid, average_us_fx, peak_us, overrun_count, cpu_load_fx,
               window_fill, output ready);
endinterface

// File: sv/lwstat_ram.sv
// lwstat_ram: generic single-write, single-read ram with registered read data
// no dependencies
module lwstat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: sv/lwstat_div.sv
// lwstat_div: restoring divider, one quotient bit per cycle, flags quotient overflow
// no dependencies
module lwstat_div #(
  parameter int NUM_W = 16,
  parameter int DEN_W = 8,
  parameter int QUO_W = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [QUO_W-1:0] quotient,
  output logic             sat
);
  localparam int CW = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;
  localparam int CNT_W = $clog2(QUO_W + 1);

  logic [CW-1:0]    rem;
  logic [CW-1:0]    ds;
  logic [CNT_W-1:0] cnt;
  logic             ge;

  assign ge = rem >= ds;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == '0) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= CW'(num);
      ds <= CW'(den) << QUO_W;
      cnt <= CNT_W'(QUO_W);
      quotient <= '0;
      sat <= 1'b0;
    end else if (busy) begin
      // first step tests den << QUO_W: quotient would not fit
      if (cnt == CNT_W'(QUO_W)) begin
        sat <= ge;
      end else begin
        quotient <= {quotient[QUO_W-2:0], ge};
        if (ge) begin
          rem <= rem - ds;
        end
      end
      ds <= ds >> 1;
      if (cnt != '0) begin
        cnt <= cnt - 1'b1;
      end
    end
  end
endmodule

// File: sv/lwstat_front.sv
// lwstat_front: takes event beats and turns elapsed ns into whole microseconds
// depends on lwstat_pkg, lwstat_event_if
module lwstat_front (
  input  logic                 clk,
  input  logic                 rst,
  lwstat_event_if.sink         events,
  output logic                 push,
  output lwstat_pkg::cmd_t     push_data,
  input  logic                 full
);
  import lwstat_pkg::*;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MUL = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  logic [1:0]           state;
  logic [ACT_W-1:0]     action;
  logic [NS_W-1:0]      ns;
  logic [US_PROD_W-1:0] prod;
  logic [LAT_W-1:0]     us_raw;

  assign events.ready = (state == F_IDLE);
  assign us_raw = prod[US_SHIFT +: LAT_W];
  assign push = (state == F_PUSH) && !full;

  always_comb begin
    push_data.action = action;
    // a nonzero time below one microsecond still counts as one
    if (ns != '0 && us_raw == '0) begin
      push_data.us = LAT_W'(1);
    end else begin
      push_data.us = us_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: if (events.valid) state <= F_MUL;
        F_MUL: state <= F_PUSH;
        F_PUSH: if (!full) state <= F_IDLE;
        default: state <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && events.valid) begin
      action <= events.action;
      ns <= events.elapsed_ns;
    end
    if (state == F_MUL) begin
      prod <= US_PROD_W'(ns) * US_PROD_W'(US_MAGIC);
    end
  end
endmodule

// File: sv/lwstat_queue.sv
// lwstat_queue: short command queue between front and back
// depends on lwstat_pkg
module lwstat_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  lwstat_pkg::cmd_t push_data,
  output logic             full,
  output logic             valid,
  output lwstat_pkg::cmd_t data,
  input  logic             pop
);
  import lwstat_pkg::*;

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign full = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign valid = (count != '0);
  assign data = entries[rptr];
  assign do_push = push && !full;
  assign do_pop = pop && valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= wptr + 1'b1;
      if (do_pop) rptr <= rptr + 1'b1;
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wptr] <= push_data;
    end
  end
endmodule

// File: sv/lwstat_back.sv
// lwstat_back: updates the latency window and computes average and load per command
// depends on lwstat_pkg, lwstat_stats_if, lwstat_ram, lwstat_div
module lwstat_back #(
  parameter int WINDOW_DEPTH = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  lwstat_pkg::cmd_t              q_data,
  output logic                          q_pop,
  input  logic [lwstat_pkg::BUF_W-1:0]  buffer_size,
  input  logic [lwstat_pkg::RATE_W-1:0] sample_rate_hz,
  lwstat_stats_if.source                stats
);
  import lwstat_pkg::*;

  localparam int PTR_W = $clog2(WINDOW_DEPTH);
  localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W = LAT_W + PTR_W;
  localparam int LPROD_W = SUM_W + RATE_W;
  localparam int DPROD_W = FILL_W + BUF_W;
  localparam int DEN_W = DPROD_W + SCALE_W;

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_UPD = 3'd1;
  localparam logic [2:0] B_MUL = 3'd2;
  localparam logic [2:0] B_MUL2 = 3'd3;
  localparam logic [2:0] B_START = 3'd4;
  localparam logic [2:0] B_WAIT = 3'd5;
  localparam logic [2:0] B_OUT = 3'd6;

  logic [2:0]         state;
  cmd_t               cmd;
  logic [PTR_W-1:0]   wp;
  logic [FILL_W-1:0]  fill;
  logic [SUM_W-1:0]   sum;
  logic [LAT_W-1:0]   peak;
  logic [OVR_W-1:0]   ovr;
  logic [LAT_W-1:0]   oldest;
  logic               full;
  logic [LPROD_W-1:0] load_prod;
  logic [DPROD_W-1:0] den_prod;
  logic [DEN_W-1:0]   den_full;
  logic               ram_we;
  logic               avg_busy;
  logic [AVG_W-1:0]   avg_q;
  logic               avg_sat;
  logic               load_busy;
  logic [LOAD_W-1:0]  load_q;
  logic               load_sat;
  logic [FILL_W+FILL_OUT_W-1:0] fill_wide;

  assign full = (fill == FILL_W'(WINDOW_DEPTH));
  assign q_pop = (state == B_IDLE) && q_valid;
  assign ram_we = (state == B_UPD) && (cmd.action == ACT_SAMPLE);
  assign stats.valid = (state == B_OUT);
  assign fill_wide = {{FILL_OUT_W{1'b0}}, fill};

  lwstat_ram #(
    .WIDTH(LAT_W),
    .DEPTH(WINDOW_DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wp),
    .wdata(cmd.us),
    .raddr(wp),
    .rdata(oldest)
  );

  lwstat_div #(
    .NUM_W(SUM_W + FRAC_BITS),
    .DEN_W(FILL_W),
    .QUO_W(AVG_W)
  ) u_avg_div (
    .clk     (clk),
    .rst     (rst),
    .start   (state == B_START),
    .num     ({sum, {FRAC_BITS{1'b0}}}),
    .den     (fill),
    .busy    (avg_busy),
    .quotient(avg_q),
    .sat     (avg_sat)
  );

  lwstat_div #(
    .NUM_W(LPROD_W + FRAC_BITS),
    .DEN_W(DEN_W),
    .QUO_W(LOAD_W)
  ) u_load_div (
    .clk     (clk),
    .rst     (rst),
    .start   (state == B_START),
    .num     ({load_prod, {FRAC_BITS{1'b0}}}),
    .den     (den_full),
    .busy    (load_busy),
    .quotient(load_q),
    .sat     (load_sat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      wp <= '0;
      fill <= '0;
      sum <= '0;
      peak <= '0;
      ovr <= '0;
    end else begin
      case (state)
        B_IDLE: if (q_valid) state <= B_UPD;
        B_UPD: begin
          state <= B_MUL;
          case (cmd.action)
            ACT_SAMPLE: begin
              // a full window drops its oldest entry, read from wp last cycle
              sum <= sum - (full ? SUM_W'(oldest) : '0) + SUM_W'(cmd.us);
              wp <= (wp == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : wp + 1'b1;
              if (!full) fill <= fill + 1'b1;
              if (cmd.us > peak) peak <= cmd.us;
            end
            ACT_OVERRUN: ovr <= ovr + 1'b1;
            ACT_CLEAR: begin
              wp <= '0;
              fill <= '0;
              sum <= '0;
              peak <= '0;
              ovr <= '0;
            end
            default: ;
          endcase
        end
        B_MUL: state <= B_MUL2;
        B_MUL2: state <= B_START;
        B_START: state <= B_WAIT;
        B_WAIT: if (!avg_busy && !load_busy) state <= B_OUT;
        B_OUT: if (stats.ready) state <= B_IDLE;
        default: state <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd <= q_data;
    end
    if (state == B_MUL) begin
      load_prod <= LPROD_W'(sum) * LPROD_W'(sample_rate_hz);
      den_prod <= DPROD_W'(fill) * DPROD_W'(buffer_size);
    end
    if (state == B_MUL2) begin
      den_full <= DEN_W'(den_prod) * DEN_W'(LOAD_SCALE);
    end
    if (state == B_WAIT && !avg_busy && !load_busy) begin
      if (fill == '0) begin
        stats.average_us_fx <= '0;
      end else begin
        stats.average_us_fx <= avg_sat ? '1 : avg_q;
      end
      if (fill == '0 || buffer_size == '0 || sample_rate_hz == '0) begin
        stats.cpu_load_fx <= '0;
      end else begin
        stats.cpu_load_fx <= load_sat ? '1 : load_q;
      end
      stats.peak_us <= peak;
      stats.overrun_count <= ovr;
      stats.window_fill <= fill_wide[FILL_OUT_W-1:0];
    end
  end
endmodule

// File: sv/latency_window_statistics.sv
// latency_window_statistics: tracks a window of processing latencies and reports
// average, peak, overrun count, cpu load and window fill for every event beat.
// channels: events (sink) carries action and elapsed_ns; stats (source) carries
// one result beat per event. config: cfg_write/cfg_index/cfg_data, index 0 is
// buffer_size, index 1 is sample_rate_hz; write only while the block is idle.
// the front captures the beat, registers the ns-to-us product and pushes into a
// 2-entry queue, so it keeps taking beats while the back works or while a result
// waits on stats. the back handles one event at a time, in order: pop, ring update,
// two multiply stages, divider start, a wait while the average divider (one
// overflow check plus 31 quotient steps) and the shorter load divider run side
// by side, then the output state, held until stats.ready. it pops the next
// event only after the result is taken.
// if stats.ready stays low the result holds, the queue fills and events.ready
// stays low once three more beats are taken (two queued, one held in the front).
// reset clears all statistics and restores buffer_size 512 and sample_rate_hz
// 48000; the ring needs no clearing pass.
// depends on lwstat_pkg, lwstat interfaces, lwstat_front, lwstat_queue, lwstat_back
module latency_window_statistics #(
  parameter int WINDOW_DEPTH = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  lwstat_event_if.sink                      events,
  lwstat_stats_if.source                    stats,
  input  logic                              cfg_write,
  input  logic [lwstat_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lwstat_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lwstat_pkg::*;

  logic [BUF_W-1:0]  buffer_size;
  logic [RATE_W-1:0] sample_rate_hz;
  logic              push;
  cmd_t              push_data;
  logic              q_full;
  logic              q_valid;
  cmd_t              q_data;
  logic              q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_size <= BUFFER_SIZE_RESET;
      sample_rate_hz <= SAMPLE_RATE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_BUFFER_SIZE: buffer_size <= cfg_data[BUF_W-1:0];
        CFG_SAMPLE_RATE: sample_rate_hz <= cfg_data[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  lwstat_front u_front (
    .clk      (clk),
    .rst      (rst),
    .events   (events),
    .push     (push),
    .push_data(push_data),
    .full     (q_full)
  );

  lwstat_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .full     (q_full),
    .valid    (q_valid),
    .data     (q_data),
    .pop      (q_pop)
  );

  lwstat_back #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_data        (q_data),
    .q_pop         (q_pop),
    .buffer_size   (buffer_size),
    .sample_rate_hz(sample_rate_hz),
    .stats         (stats)
  );
endmodule
